@@ rtl/lcdr_pkg.sv @@
// Shared constants, types and the high-code translation table of the LCD refresh scanner.
// No dependencies; every other file imports this package except lcdr_if and lcdr_checker.
`default_nettype none

package lcdr_pkg;

  localparam int COLUMNS = 16;
  localparam int ROWS    = 2;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CMD_ROW0   = 8'h80;
  localparam logic [7:0] CMD_ROW1   = 8'hC0;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // One tick's worth of work for the nibble sequencer
  typedef struct packed {
    logic       wrap;     // send a set-address command first
    logic       row_one;  // address command targets row 1
    logic [7:0] ch;       // translated character byte
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_head_t;

  function automatic logic [7:0] code_lookup(input logic [6:0] idx);
    logic [7:0] r;
    case (idx)
      7'd0:   r = 8'hD9;  7'd1:   r = 8'hDA;
      7'd48:  r = 8'hA2;  7'd49:  r = 8'hB5;
      7'd64:  r = 8'h41;  7'd65:  r = 8'hA0;  7'd66:  r = 8'h42;  7'd67:  r = 8'hA1;
      7'd68:  r = 8'hE0;  7'd69:  r = 8'h45;  7'd70:  r = 8'hA3;  7'd71:  r = 8'hA4;
      7'd72:  r = 8'hA5;  7'd73:  r = 8'hA6;  7'd74:  r = 8'h4B;  7'd75:  r = 8'hA7;
      7'd76:  r = 8'h4D;  7'd77:  r = 8'h48;  7'd78:  r = 8'h4F;  7'd79:  r = 8'hA8;
      7'd80:  r = 8'h50;  7'd81:  r = 8'h43;  7'd82:  r = 8'h54;  7'd83:  r = 8'hA9;
      7'd84:  r = 8'hAA;  7'd85:  r = 8'h58;  7'd86:  r = 8'hE1;  7'd87:  r = 8'hAB;
      7'd88:  r = 8'hAC;  7'd89:  r = 8'hE2;  7'd90:  r = 8'hAD;  7'd91:  r = 8'hAE;
      7'd92:  r = 8'h62;  7'd93:  r = 8'hAF;  7'd94:  r = 8'hB0;  7'd95:  r = 8'hB1;
      7'd96:  r = 8'h61;  7'd97:  r = 8'hB2;  7'd98:  r = 8'hB3;  7'd99:  r = 8'hB4;
      7'd100: r = 8'hE3;  7'd101: r = 8'h65;  7'd102: r = 8'hB6;  7'd103: r = 8'hB7;
      7'd104: r = 8'hB8;  7'd105: r = 8'hB9;  7'd106: r = 8'hBA;  7'd107: r = 8'hBB;
      7'd108: r = 8'hBC;  7'd109: r = 8'hBD;  7'd110: r = 8'h6F;  7'd111: r = 8'hBE;
      7'd112: r = 8'h70;  7'd113: r = 8'h63;  7'd114: r = 8'hBF;  7'd115: r = 8'h79;
      7'd116: r = 8'hE4;  7'd117: r = 8'h78;  7'd118: r = 8'hE5;  7'd119: r = 8'hC0;
      7'd120: r = 8'hC1;  7'd121: r = 8'hE6;  7'd122: r = 8'hC2;  7'd123: r = 8'hC3;
      7'd124: r = 8'hC4;  7'd125: r = 8'hC5;  7'd126: r = 8'hC6;  7'd127: r = 8'hC7;
      default: r = CHAR_SPACE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lcdr_if.sv @@
// Valid/ready channel interfaces for the item input and the nibble output.
// Depends on nothing but the fixed field widths.
`default_nettype none

interface lcdr_item_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [4:0] cell_index;
  logic [7:0] cell_char;
  modport source (output valid, command, cell_index, cell_char, input ready);
  modport sink   (input valid, command, cell_index, cell_char, output ready);
endinterface

interface lcdr_nibble_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic [3:0] bus_nibble;
  logic       last_of_tick;
  modport source (output valid, register_select, bus_nibble, last_of_tick, input ready);
  modport sink   (input valid, register_select, bus_nibble, last_of_tick, output ready);
endinterface

`default_nettype wire

@@ rtl/lcdr_front.sv @@
// Front end: takes items, keeps the screen store and scan position, queues one job per tick.
// Depends on lcdr_pkg and lcdr_item_if.
`default_nettype none

module lcdr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  lcdr_item_if.sink          items,
  input  wire logic          q_full,
  output logic               q_push,
  output lcdr_pkg::job_t     q_job
);
  import lcdr_pkg::*;

  logic [7:0]       store [CELLS];
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             wrap;
  logic             row_wrap;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [CELL_W-1:0] rd_cell;
  logic [7:0]       raw_ch;
  logic             accept;
  logic             wr_en;

  assign items.ready = !q_full;
  assign accept      = items.valid && items.ready;
  assign wr_en       = accept && (items.command == CMD_WRITE) && (int'(items.cell_index) < CELLS);

  always_comb begin
    col_inc  = {1'b0, col} + 1'b1;
    row_inc  = {1'b0, row} + 1'b1;
    wrap     = int'(col_inc) >= COLUMNS;
    row_wrap = int'(row_inc) >= ROWS;
    col_next = wrap ? '0 : col_inc[COL_W-1:0];
    if (!wrap) begin
      row_next = row;
    end else if (row_wrap) begin
      row_next = '0;
    end else begin
      row_next = row_inc[ROW_W-1:0];
    end
    rd_cell       = CELL_W'(int'(row_next) * COLUMNS + int'(col_next));
    raw_ch        = store[rd_cell];
    q_job.wrap    = wrap;
    q_job.row_one = !row_wrap;
    q_job.ch      = raw_ch[7] ? code_lookup(raw_ch[6:0]) : raw_ch;
    q_push        = accept && (items.command == CMD_TICK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (q_push) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Store starts out blank; reset fills every cell with a space
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) store[i] <= CHAR_SPACE;
    end else if (wr_en) begin
      store[CELL_W'(items.cell_index)] <= items.cell_char;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lcdr_queue.sv @@
// Short job queue between the front end and the nibble sequencer.
// Depends on lcdr_pkg.
`default_nettype none

module lcdr_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire lcdr_pkg::job_t    push_job,
  output logic                   full,
  input  wire logic              pop,
  output lcdr_pkg::job_head_t    head
);
  import lcdr_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = int'(count) == QDEPTH;
  assign head.valid = count != '0;
  assign head.job   = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (int'(wr_ptr) == QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (int'(rd_ptr) == QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

`default_nettype wire

@@ rtl/lcdr_back.sv @@
// Back end: splits each queued job into command and data nibbles into an output register.
// Depends on lcdr_pkg and lcdr_nibble_if.
`default_nettype none

module lcdr_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lcdr_pkg::job_head_t head,
  output logic                     pop,
  lcdr_nibble_if.source            nibbles
);
  import lcdr_pkg::*;

  logic [1:0] step;
  logic [1:0] phase;
  logic       load;
  logic       job_done;
  logic [7:0] cmd_byte;
  logic [7:0] cur_byte;
  logic       out_valid;
  logic       out_rs;
  logic [3:0] out_nibble;
  logic       out_last;

  // phase 0/1: address command nibbles, 2/3: character nibbles
  always_comb begin
    phase    = head.job.wrap ? step : {1'b1, step[0]};
    load     = head.valid && (!out_valid || nibbles.ready);
    job_done = (phase == 2'd3);
    pop      = load && job_done;
    cmd_byte = head.job.row_one ? CMD_ROW1 : CMD_ROW0;
    cur_byte = phase[1] ? head.job.ch : cmd_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= job_done ? 2'd0 : step + 1'b1;
        out_valid <= 1'b1;
      end else if (nibbles.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rs     <= phase[1];
      out_nibble <= phase[0] ? cur_byte[3:0] : cur_byte[7:4];
      out_last   <= job_done;
    end
  end

  assign nibbles.valid           = out_valid;
  assign nibbles.register_select = out_rs;
  assign nibbles.bus_nibble      = out_nibble;
  assign nibbles.last_of_tick    = out_last;

endmodule

`default_nettype wire

@@ rtl/char_lcd_refresh_scanner_core.sv @@
// Character LCD refresh scanner: screen store, scan position and 4-bit bus nibble sequencer.
// Depends on lcdr_pkg, lcdr_if, lcdr_front, lcdr_queue and lcdr_back.
//
// Usage:
//   items carries write items (command 0: store cell_char at cell_index, no output;
//   indexes past the screen are dropped) and tick items (command 1: advance the scan
//   position and re-send one character).
//   nibbles carries one 4-bit bus value per beat, high nibble first. A tick gives two
//   data nibbles, or four when the column wraps: the set-address command (0x80/0xC0,
//   register_select low) and then the character. last_of_tick marks the final beat.
// The first nibble of a tick goes through the job queue and then the output register.
// Throughput: one nibble a cycle from the output register while nibbles.ready is high and a
//   job is queued; a write gives no nibbles. The nibble sequencer sets the sustained rate.
// A two-entry job queue sits between the front end and the sequencer; the character is
//   read and translated when the tick is accepted, so later writes do not alter it.
// Stall: while nibbles.ready is low the output beat holds; items.ready drops once the
//   queue is full.
// Reset: the store fills with spaces in the reset cycle, the scan position returns to
//   row 0 column 0 and the queue and output register empty. No clearing pass follows.
`default_nettype none

module char_lcd_refresh_scanner_core (
  input  wire logic     clk,
  input  wire logic     rst,
  lcdr_item_if.sink     items,
  lcdr_nibble_if.source nibbles
);
  import lcdr_pkg::*;

  logic      q_full;
  logic      q_push;
  job_t      q_job;
  logic      q_pop;
  job_head_t q_head;

  lcdr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  lcdr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  lcdr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .pop     (q_pop),
    .nibbles (nibbles)
  );

endmodule

`default_nettype wire

@@ rtl/lcdr_checker.sv @@
// Port-level checks on the LCD refresh scanner, bound to the top level.
// Depends only on the top level's port signals.
`default_nettype none

module lcdr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_rs,
  input wire logic [3:0] out_nibble,
  input wire logic       out_last
);

  // Hold a stalled beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_nibble) && $stable(out_rs)
      && $stable(out_last))
    else $error("stalled nibble changed");

  // A tick always ends on a data nibble
  a_last_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_rs)
    else $error("last nibble is not data");

  // Command nibbles are followed by at least one more beat
  a_cmd_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rs |-> !out_last)
    else $error("command nibble marked last");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind char_lcd_refresh_scanner_core lcdr_checker u_lcdr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (nibbles.valid),
  .out_ready  (nibbles.ready),
  .out_rs     (nibbles.register_select),
  .out_nibble (nibbles.bus_nibble),
  .out_last   (nibbles.last_of_tick)
);

`default_nettype wire

@@ sim/lcdr_bus_checker.sv @@
`timescale 1ns / 1ps
// Bus checker for the LCD refresh scanner: watches the item and nibble channels,
// predicts every bus beat and compares. Depends on lcdr_pkg and lcdr_if.
module lcdr_bus_checker (
  input  wire logic clk,
  input  wire logic rst,
  lcdr_item_if      items,
  lcdr_nibble_if    nibbles,
  output int        failures,
  output int        pending
);
  import lcdr_pkg::*;

  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic       last;
  } bus_beat_t;

  // Display codes for characters 0x80 to 0xFF, indexed by the low seven bits
  localparam logic [7:0] HIGH_CODE_MAP [0:127] = '{
    'hD9, 'hDA, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20,
    'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20,
    'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20,
    'hA2, 'hB5, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20, 'h20,
    'h41, 'hA0, 'h42, 'hA1, 'hE0, 'h45, 'hA3, 'hA4, 'hA5, 'hA6, 'h4B, 'hA7, 'h4D, 'h48, 'h4F, 'hA8,
    'h50, 'h43, 'h54, 'hA9, 'hAA, 'h58, 'hE1, 'hAB, 'hAC, 'hE2, 'hAD, 'hAE, 'h62, 'hAF, 'hB0, 'hB1,
    'h61, 'hB2, 'hB3, 'hB4, 'hE3, 'h65, 'hB6, 'hB7, 'hB8, 'hB9, 'hBA, 'hBB, 'hBC, 'hBD, 'h6F, 'hBE,
    'h70, 'h63, 'hBF, 'h79, 'hE4, 'h78, 'hE5, 'hC0, 'hC1, 'hE6, 'hC2, 'hC3, 'hC4, 'hC5, 'hC6, 'hC7
  };

  logic [7:0]       screen_copy [CELLS];
  logic [COL_W-1:0] scan_col;
  logic [ROW_W-1:0] scan_row;
  bus_beat_t        expected_beats [$];

  initial failures = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    failures++;
  endtask

  function automatic logic [7:0] display_code(input logic [7:0] ch);
    if (ch[7]) return HIGH_CODE_MAP[ch[6:0]];
    return ch;
  endfunction

  task automatic queue_byte(input logic rs, input logic [7:0] b, input logic last);
    expected_beats.push_back('{rs, b[7:4], 1'b0});
    expected_beats.push_back('{rs, b[3:0], last});
  endtask

  // Advance first, then send; a column wrap puts the set-address byte ahead
  task automatic predict_tick_beats();
    int col;
    int row;
    int cell_pos;
    logic [7:0] ch;
    col = int'(scan_col) + 1;
    row = int'(scan_row);
    if (col >= COLUMNS) begin
      col = 0;
      row++;
      if (row >= ROWS) begin
        row = 0;
        queue_byte(RS_COMMAND, CMD_ROW0, 1'b0);
      end else begin
        queue_byte(RS_COMMAND, CMD_ROW1, 1'b0);
      end
    end
    scan_col = col[COL_W-1:0];
    scan_row = row[ROW_W-1:0];
    cell_pos = row * COLUMNS + col;
    ch = (cell_pos < CELLS) ? screen_copy[cell_pos] : CHAR_SPACE;
    queue_byte(RS_DATA, display_code(ch), 1'b1);
  endtask

  task automatic check_beat();
    bus_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("beat with none expected: rs=%0b nibble=%h last=%0b",
                                nibbles.register_select, nibbles.bus_nibble,
                                nibbles.last_of_tick));
      return;
    end
    want = expected_beats.pop_front();
    if (nibbles.register_select !== want.rs)
      report_mismatch($sformatf("register_select %0b, want %0b",
                                nibbles.register_select, want.rs));
    if (nibbles.bus_nibble !== want.nibble)
      report_mismatch($sformatf("bus_nibble %h, want %h", nibbles.bus_nibble, want.nibble));
    if (nibbles.last_of_tick !== want.last)
      report_mismatch($sformatf("last_of_tick %0b, want %0b",
                                nibbles.last_of_tick, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen_copy[i] = CHAR_SPACE;
      scan_col = '0;
      scan_row = '0;
      expected_beats.delete();
    end else begin
      if (items.valid && items.ready) begin
        if (items.command == CMD_TICK) begin
          predict_tick_beats();
        end else if (int'(items.cell_index) < CELLS) begin
          screen_copy[items.cell_index] = items.cell_char;
        end
      end
      if (nibbles.valid && nibbles.ready) check_beat();
    end
    pending <= expected_beats.size();
  end

endmodule

@@ sim/char_lcd_refresh_scanner_core_test.sv @@
`timescale 1ns / 1ps
// Top of the LCD refresh scanner test: clock, reset, item stimulus and bus stalls.
// Depends on lcdr_pkg, lcdr_if, the scanner core and lcdr_bus_checker.
module char_lcd_refresh_scanner_core_test;
  import lcdr_pkg::*;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic clk = 1'b0;
  logic rst;
  logic hold_go;
  int   failures;
  int   pending;
  int   burst_left = 0;

  lcdr_item_if   items_if();
  lcdr_nibble_if nibbles_if();

  char_lcd_refresh_scanner_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .nibbles (nibbles_if)
  );

  lcdr_bus_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .items    (items_if),
    .nibbles  (nibbles_if),
    .failures (failures),
    .pending  (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one beat; a burst boundary drops valid for a random gap first
  task automatic send_item(input logic cmd, input logic [4:0] idx, input logic [7:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        items_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    items_if.valid      <= 1'b1;
    items_if.command    <= cmd;
    items_if.cell_index <= idx;
    items_if.cell_char  <= ch;
    do @(posedge clk); while (!items_if.ready);
  endtask

  initial begin
    logic [7:0] ch;
    rst                 <= 1'b1;
    hold_go             <= 1'b0;
    items_if.valid      <= 1'b0;
    items_if.command    <= CMD_WRITE;
    items_if.cell_index <= '0;
    items_if.cell_char  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // High codes, pass-through codes and both index extremes
    send_item(CMD_WRITE, 5'd1, 8'hFF);
    send_item(CMD_WRITE, 5'd2, 8'h80);
    send_item(CMD_WRITE, 5'd3, 8'h7F);
    send_item(CMD_WRITE, 5'd0, 8'h00);
    send_item(CMD_WRITE, 5'd16, 8'hB0);
    send_item(CMD_WRITE, 5'd17, 8'h81);
    send_item(CMD_WRITE, 5'd31, 8'hC0);
    // First tick shows cell 1; the sixteenth wraps into row one
    repeat (17) send_item(CMD_TICK, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));

    for (int n = 0; n < 120; n++) begin
      if (n == 30) hold_go <= 1'b1;
      ch = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(128, 255));
      send_item(($urandom_range(0, 9) < 6) ? CMD_TICK : CMD_WRITE,
                5'($urandom_range(0, 31)), ch);
    end
    items_if.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver stalls in runs of random mode; one long hold-off fills the block
  initial begin
    rx_mode_e mode;
    int       run;
    bit       held;
    nibbles_if.ready <= 1'b0;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        repeat (160) begin
          @(posedge clk);
          nibbles_if.ready <= 1'b0;
        end
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      run  = $urandom_range(8, 48);
      repeat (run) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:   nibbles_if.ready <= 1'b1;
          RX_COIN:   nibbles_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: nibbles_if.ready <= ($urandom_range(0, 3) == 0);
          default:   nibbles_if.ready <= ~nibbles_if.ready;
        endcase
      end
    end
  end

endmodule
